@@ hw/rtl/air_quality_index_calc_unit_assert.svh @@
// assertion macros for the air quality index unit
// expects clk and rst_n in the scope where a macro is used
`ifndef AIR_QUALITY_INDEX_CALC_UNIT_ASSERT_SVH
`define AIR_QUALITY_INDEX_CALC_UNIT_ASSERT_SVH

// same-cycle implication
`define AQIC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aqic assertion failed");

// implication with a fixed delay written into the consequent
`define AQIC_ASSERT_SEQ(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("aqic latency assertion failed");

`endif

@@ hw/rtl/aqic_pkg.sv @@
// shared types, breakpoint tables and constants for the air quality index unit
// no dependencies
`default_nettype none

package aqic_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NUM_SEGMENTS = 6;
    localparam int LANES        = 2;
    localparam int SEG_W        = $clog2(NUM_SEGMENTS);

    localparam int GAIN_W = 17;
    localparam int COEF_W = 16;
    localparam int OFFS_W = 20;
    localparam int RAW_W  = 16;
    localparam int HUM_W  = 8;
    localparam int IDX_W  = 9;

    localparam int PGAIN_W = GAIN_W + RAW_W;     // gain * raw
    localparam int PHUM_W  = COEF_W + HUM_W;     // coef * humidity
    localparam int CORR_W  = PGAIN_W + 1;        // clamped corrected value
    localparam int WHOLE_W = CORR_W - FRAC_BITS; // integer part
    localparam int DIFF_W  = 24;                 // offset into a segment, fraction included
    localparam int QIN_W   = 16;                 // rounded numerator over 2^FRAC_BITS
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = 21;
    localparam int QUO_W    = 9;

    localparam int LATENCY = 7;

    localparam logic [IDX_W-1:0] AQI_MAX = 9'd500;

    localparam logic [GAIN_W-1:0] GAIN_RST = 17'd34996;
    localparam logic [COEF_W-1:0] COEF_RST = 16'd5531;
    localparam logic [OFFS_W-1:0] OFFS_RST = 20'd367264;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_HUMCOEF = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam int LANE_FINE   = 0;
    localparam int LANE_COARSE = 1;

    // concentration breakpoints, fine lane then coarse lane
    localparam logic [9:0] SEG_LO [LANES][NUM_SEGMENTS] = '{
        '{10'd0, 10'd13, 10'd36, 10'd56, 10'd151, 10'd251},
        '{10'd0, 10'd55, 10'd155, 10'd255, 10'd355, 10'd425}};
    localparam logic [9:0] SEG_HI [LANES][NUM_SEGMENTS] = '{
        '{10'd12, 10'd35, 10'd55, 10'd150, 10'd250, 10'd500},
        '{10'd54, 10'd154, 10'd254, 10'd354, 10'd424, 10'd604}};
    localparam logic [7:0] SEG_SPAN [LANES][NUM_SEGMENTS] = '{
        '{8'd12, 8'd22, 8'd19, 8'd94, 8'd99, 8'd249},
        '{8'd54, 8'd99, 8'd99, 8'd99, 8'd69, 8'd179}};
    // floor(2^RECIP_SH / span)
    localparam logic [RECIP_W-1:0] SEG_RECIP [LANES][NUM_SEGMENTS] = '{
        '{21'((1 << RECIP_SH) / 12), 21'((1 << RECIP_SH) / 22),
          21'((1 << RECIP_SH) / 19), 21'((1 << RECIP_SH) / 94),
          21'((1 << RECIP_SH) / 99), 21'((1 << RECIP_SH) / 249)},
        '{21'((1 << RECIP_SH) / 54), 21'((1 << RECIP_SH) / 99),
          21'((1 << RECIP_SH) / 99), 21'((1 << RECIP_SH) / 99),
          21'((1 << RECIP_SH) / 69), 21'((1 << RECIP_SH) / 179)}};

    // index bands
    localparam logic [IDX_W-1:0] BAND_LO [NUM_SEGMENTS] = '{
        9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};
    localparam logic [7:0] BAND_SPAN [NUM_SEGMENTS] = '{
        8'd50, 8'd49, 8'd49, 8'd49, 8'd99, 8'd199};

    typedef struct packed {
        logic [RAW_W-1:0] pm25_raw;
        logic [RAW_W-1:0] pm10_raw;
        logic [HUM_W-1:0] rel_humidity;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] pm25_subindex;
        logic [IDX_W-1:0] pm10_subindex;
        logic [IDX_W-1:0] aqi;
    } out_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [COEF_W-1:0] coef;
        logic [OFFS_W-1:0] offset;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/aqic_correct.sv @@
// humidity correction stages: products, then offset sum and clamp at zero
// depends on aqic_pkg
`default_nettype none

module aqic_correct (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          valid_in,
    input  wire logic [aqic_pkg::LANES-1:0][aqic_pkg::RAW_W-1:0] raw,
    input  wire logic [aqic_pkg::HUM_W-1:0]                    hum,
    input  wire aqic_pkg::cfg_t                                cfg,
    output logic                                               valid_out,
    output logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W-1:0]   corr
);

    logic                                                 v1_reg;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::PGAIN_W-1:0]    pg_reg;
    logic [aqic_pkg::PHUM_W-1:0]                          ph_reg;
    logic                                                 v2_reg;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W-1:0]     c_reg;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W-1:0]     c_next;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W:0]       sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: multiplies
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < aqic_pkg::LANES; l++)
        begin
            pg_reg[l] <= aqic_pkg::PGAIN_W'(cfg.gain) * aqic_pkg::PGAIN_W'(raw[l]);
        end
        ph_reg <= aqic_pkg::PHUM_W'(cfg.coef) * aqic_pkg::PHUM_W'(hum);
    end

    // stage 2: signed sum, negative clamps to zero
    always_comb
    begin
        for (int l = 0; l < aqic_pkg::LANES; l++)
        begin
            sum[l] = (aqic_pkg::CORR_W + 1)'(pg_reg[l])
                   + (aqic_pkg::CORR_W + 1)'(cfg.offset)
                   - (aqic_pkg::CORR_W + 1)'(ph_reg);
            c_next[l] = sum[l][aqic_pkg::CORR_W] ? '0 : sum[l][aqic_pkg::CORR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign valid_out = v2_reg;
    assign corr      = c_reg;

endmodule

`default_nettype wire

@@ hw/rtl/aqic_interp.sv @@
// segment search and rounded linear interpolation, one lane per pollutant
// depends on aqic_pkg
`default_nettype none

module aqic_interp (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          valid_in,
    input  wire logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W-1:0] corr,
    output logic                                               valid_out,
    output logic [aqic_pkg::LANES-1:0][aqic_pkg::IDX_W-1:0]    sub
);

    localparam int SEG_W = aqic_pkg::SEG_W;

    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    for (genvar lane = 0; lane < aqic_pkg::LANES; lane++)
    begin : g_lane
        logic [aqic_pkg::WHOLE_W-1:0] whole;
        logic                         hit_next;
        logic [SEG_W-1:0]             seg_next;
        logic [aqic_pkg::DIFF_W-1:0]  d_next;
        logic [aqic_pkg::CORR_W-1:0]  base;

        logic                         hit3_reg;
        logic [SEG_W-1:0]             seg3_reg;
        logic [aqic_pkg::DIFF_W-1:0]  d3_reg;

        logic [32:0]                  num;
        logic                         hit4_reg;
        logic [SEG_W-1:0]             seg4_reg;
        logic [aqic_pkg::QIN_W-1:0]   m4_reg;

        logic [aqic_pkg::QIN_W+aqic_pkg::RECIP_W-1:0] prod;
        logic                         hit5_reg;
        logic [SEG_W-1:0]             seg5_reg;
        logic [aqic_pkg::QIN_W-1:0]   m5_reg;
        logic [aqic_pkg::QUO_W-1:0]   q5_reg;

        logic [aqic_pkg::QIN_W:0]     qs;
        logic [aqic_pkg::QIN_W:0]     rem;
        logic [aqic_pkg::QUO_W-1:0]   q;
        logic [aqic_pkg::IDX_W:0]     r;
        logic [aqic_pkg::IDX_W-1:0]   sub_next;
        logic [aqic_pkg::IDX_W-1:0]   sub6_reg;

        // stage 3: first segment whose integer range holds the value
        always_comb
        begin
            whole    = corr[lane][aqic_pkg::CORR_W-1:aqic_pkg::FRAC_BITS];
            hit_next = 1'b0;
            seg_next = '0;
            for (int k = aqic_pkg::NUM_SEGMENTS - 1; k >= 0; k--)
            begin
                if (whole >= aqic_pkg::WHOLE_W'(aqic_pkg::SEG_LO[lane][k]) &&
                    whole <= aqic_pkg::WHOLE_W'(aqic_pkg::SEG_HI[lane][k]))
                begin
                    hit_next = 1'b1;
                    seg_next = SEG_W'(k);
                end
            end
            base   = aqic_pkg::CORR_W'(aqic_pkg::SEG_LO[lane][seg_next]) << aqic_pkg::FRAC_BITS;
            d_next = aqic_pkg::DIFF_W'(corr[lane] - base);
        end

        always_ff @(posedge clk)
        begin
            hit3_reg <= hit_next;
            seg3_reg <= seg_next;
            d3_reg   <= d_next;
        end

        // stage 4: band * offset plus half the divisor, scaled down by the fraction
        assign num = 33'(aqic_pkg::BAND_SPAN[seg3_reg]) * 33'(d3_reg)
                   + (33'(aqic_pkg::SEG_SPAN[lane][seg3_reg]) << (aqic_pkg::FRAC_BITS - 1));

        always_ff @(posedge clk)
        begin
            hit4_reg <= hit3_reg;
            seg4_reg <= seg3_reg;
            m4_reg   <= num[aqic_pkg::FRAC_BITS +: aqic_pkg::QIN_W];
        end

        // stage 5: quotient estimate by reciprocal, low by at most one
        assign prod = (aqic_pkg::QIN_W + aqic_pkg::RECIP_W)'(m4_reg)
                    * (aqic_pkg::QIN_W + aqic_pkg::RECIP_W)'(aqic_pkg::SEG_RECIP[lane][seg4_reg]);

        always_ff @(posedge clk)
        begin
            hit5_reg <= hit4_reg;
            seg5_reg <= seg4_reg;
            m5_reg   <= m4_reg;
            q5_reg   <= prod[aqic_pkg::RECIP_SH +: aqic_pkg::QUO_W];
        end

        // stage 6: remainder correction, band offset, saturation
        always_comb
        begin
            qs  = (aqic_pkg::QIN_W + 1)'(q5_reg)
                * (aqic_pkg::QIN_W + 1)'(aqic_pkg::SEG_SPAN[lane][seg5_reg]);
            rem = (aqic_pkg::QIN_W + 1)'(m5_reg) - qs;
            q   = q5_reg;
            if (rem >= (aqic_pkg::QIN_W + 1)'(aqic_pkg::SEG_SPAN[lane][seg5_reg]))
            begin
                q = q5_reg + 1'b1;
            end
            r = (aqic_pkg::IDX_W + 1)'(aqic_pkg::BAND_LO[seg5_reg]) + (aqic_pkg::IDX_W + 1)'(q);
            if (!hit5_reg || r > (aqic_pkg::IDX_W + 1)'(aqic_pkg::AQI_MAX))
            begin
                sub_next = aqic_pkg::AQI_MAX;
            end
            else
            begin
                sub_next = r[aqic_pkg::IDX_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            sub6_reg <= sub_next;
        end

        assign sub[lane] = sub6_reg;
    end

    assign valid_out = v6_reg;

endmodule

`default_nettype wire

@@ hw/rtl/air_quality_index_calc_unit.sv @@
// air quality index unit: pm2.5 and pm10 sub-indices plus their maximum
// a word accepted at a clock edge passes the register stages below in order and is then shown
// on done/result; throughput one word per cycle
// seven register stages (two multiply/correct, four search/interpolate, one max)
// busy never rises, so a new word can follow every cycle; the result side never stalls
// rst_n asynchronous: clears all valid bits and loads the default correction registers
`default_nettype none

module air_quality_index_calc_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command side
    input  wire logic               start,
    output logic                    busy,
    input  wire aqic_pkg::in_word_t cmd,
    // result side
    output logic                    done,
    output aqic_pkg::out_word_t     result,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // correction registers
    aqic_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain   <= aqic_pkg::GAIN_RST;
            cfg_reg.coef   <= aqic_pkg::COEF_RST;
            cfg_reg.offset <= aqic_pkg::OFFS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                aqic_pkg::REG_GAIN:    cfg_reg.gain   <= pwdata[aqic_pkg::GAIN_W-1:0];
                aqic_pkg::REG_HUMCOEF: cfg_reg.coef   <= pwdata[aqic_pkg::COEF_W-1:0];
                aqic_pkg::REG_OFFSET:  cfg_reg.offset <= pwdata[aqic_pkg::OFFS_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            aqic_pkg::REG_GAIN:    prdata = 32'(cfg_reg.gain);
            aqic_pkg::REG_HUMCOEF: prdata = 32'(cfg_reg.coef);
            aqic_pkg::REG_OFFSET:  prdata = 32'(cfg_reg.offset);
            default:               prdata = '0;
        endcase
    end

    // the pipeline takes a word every cycle
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic [aqic_pkg::LANES-1:0][aqic_pkg::RAW_W-1:0] raw;
    assign raw[aqic_pkg::LANE_FINE]   = cmd.pm25_raw;
    assign raw[aqic_pkg::LANE_COARSE] = cmd.pm10_raw;

    logic                                              corr_valid;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::CORR_W-1:0]  corr;
    logic                                              sub_valid;
    logic [aqic_pkg::LANES-1:0][aqic_pkg::IDX_W-1:0]   sub;

    // stages 1-2: humidity correction for both pollutants
    aqic_correct u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .raw       (raw),
        .hum       (cmd.rel_humidity),
        .cfg       (cfg_reg),
        .valid_out (corr_valid),
        .corr      (corr)
    );

    // stages 3-6: breakpoint search and interpolation
    aqic_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (corr_valid),
        .corr      (corr),
        .valid_out (sub_valid),
        .sub       (sub)
    );

    // stage 7: overall index and result register
    logic                done_reg;
    aqic_pkg::out_word_t res_reg;
    aqic_pkg::out_word_t res_next;

    always_comb
    begin
        res_next.pm25_subindex = sub[aqic_pkg::LANE_FINE];
        res_next.pm10_subindex = sub[aqic_pkg::LANE_COARSE];
        res_next.aqi = (sub[aqic_pkg::LANE_FINE] > sub[aqic_pkg::LANE_COARSE]) ?
                       sub[aqic_pkg::LANE_FINE] : sub[aqic_pkg::LANE_COARSE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sub_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // checks
    `include "air_quality_index_calc_unit_assert.svh"

    `AQIC_ASSERT_SEQ(a_latency, accept, ##(aqic_pkg::LATENCY) done)
    `AQIC_ASSERT_NOW(a_aqi_is_max, done, (result.aqi >= result.pm25_subindex) && (result.aqi >= result.pm10_subindex) && ((result.aqi == result.pm25_subindex) || (result.aqi == result.pm10_subindex)))
    `AQIC_ASSERT_NOW(a_range, done, (result.pm25_subindex <= aqic_pkg::AQI_MAX) && (result.pm10_subindex <= aqic_pkg::AQI_MAX))

endmodule

`default_nettype wire
